// ===== hw/rtl/tlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfq_pkg
// Shared types, codes and helpers for the three-level feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfq_pkg;

  localparam int TASK_SLOTS_DEF = 16;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] LV_NONE = 2'd0;
  localparam logic [1:0] LV_1    = 2'd1;
  localparam logic [1:0] LV_2    = 2'd2;
  localparam logic [1:0] LV_3    = 2'd3;

  localparam logic [1:0] GRP_STAY = 2'd0;

  localparam logic [7:0]  PRIO_L1   = 8'd100;
  localparam logic [7:0]  PRIO_L2   = 8'd50;
  localparam logic [7:0]  PRIO_STEP = 8'd10;
  localparam logic [7:0]  PRIO_CAP  = 8'd140;
  localparam logic [7:0]  PRIO_MAX  = 8'd149;
  localparam logic [9:0]  TICK_RST  = 10'd100;
  localparam logic [11:0] THR_RST   = 12'd400;

  typedef enum logic [1:0] {
    FN_INS = 2'd0,
    FN_SEL = 2'd1,
    FN_AGE = 2'd2,
    FN_NOP = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    PH_NONE = 4'd0,
    PH_INS  = 4'd1,
    PH_SEL  = 4'd2,
    PH_CLR  = 4'd3,
    PH_FIX  = 4'd4,
    PH_AGE  = 4'd5,
    PH_LOAD = 4'd6,
    PH_KEY  = 4'd7,
    PH_CNT  = 4'd8,
    PH_NWR  = 4'd9,
    PH_COPY = 4'd10
  } phase_t;

  typedef struct packed {
    logic   start_op;
    logic   scan_clr;
    phase_t phase;
    logic   finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic row_last;
    logic ins_hit;
    logic full;
    logic found;
  } sts_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] wait_t;
  } slot_t;

  function automatic logic [1:0] level_of(input logic [7:0] p);
    logic [1:0] lv;
    if (p >= PRIO_L1) begin
      lv = LV_1;
    end else if (p >= PRIO_L2) begin
      lv = LV_2;
    end else begin
      lv = LV_3;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlfq_ctrl
// Sequencer: steps the datapath through insert, select and aging passes.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [1:0]    in_func,
  input  wire tlfq_pkg::sts_t sts,
  output tlfq_pkg::cmd_t     cmd,
  output logic               busy
);
  import tlfq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_INS  = 12'h002,
    S_SEL  = 12'h004,
    S_CLR  = 12'h008,
    S_FIX  = 12'h010,
    S_AGE  = 12'h020,
    S_LOAD = 12'h040,
    S_KEY  = 12'h080,
    S_CNT  = 12'h100,
    S_NWR  = 12'h200,
    S_COPY = 12'h400,
    S_DONE = 12'h800
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '{start_op: 1'b0, scan_clr: 1'b0, phase: PH_NONE, finish: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.start_op = 1'b1;
          cmd.scan_clr = 1'b1;
          case (func_t'(in_func))
            FN_INS:  state_nxt = S_INS;
            FN_SEL:  state_nxt = S_SEL;
            FN_AGE:  state_nxt = S_AGE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INS: begin
        cmd.phase = PH_INS;
        if (sts.full || sts.ins_hit) state_nxt = S_DONE;
      end
      S_SEL: begin
        cmd.phase = PH_SEL;
        if (sts.scan_done) state_nxt = S_CLR;
      end
      S_CLR: begin
        cmd.phase    = PH_CLR;
        cmd.scan_clr = 1'b1;
        state_nxt    = sts.found ? S_FIX : S_DONE;
      end
      S_FIX: begin
        cmd.phase = PH_FIX;
        if (sts.scan_done) state_nxt = S_DONE;
      end
      S_AGE: begin
        cmd.phase = PH_AGE;
        if (sts.scan_done) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.phase = PH_LOAD;
        state_nxt = S_KEY;
      end
      S_KEY: begin
        cmd.phase    = PH_KEY;
        cmd.scan_clr = 1'b1;
        state_nxt    = S_CNT;
      end
      S_CNT: begin
        cmd.phase = PH_CNT;
        if (sts.scan_done) state_nxt = S_NWR;
      end
      S_NWR: begin
        cmd.phase = PH_NWR;
        if (sts.row_last) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_COPY;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_COPY: begin
        cmd.phase = PH_COPY;
        if (sts.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/tlfq_dp.sv =====
// ----------------------------------------------------------------------------
// tlfq_dp
// Datapath: task table memories, scan counters, selection and aging logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfq_dp #(
  parameter int TASK_SLOTS = tlfq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlfq_pkg::cmd_t cmd,
  output tlfq_pkg::sts_t      sts,
  input  wire logic           cfg_we,
  input  wire logic           cfg_sel,
  input  wire logic [31:0]    cfg_wdata,
  output logic [31:0]         cfg_rdata,
  input  wire logic [7:0]     in_task_id,
  input  wire logic [7:0]     in_task_priority,
  input  wire logic [15:0]    in_task_burst,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic                out_sel_valid,
  output logic [7:0]          out_sel_id,
  output logic [7:0]          out_sel_priority,
  output logic [15:0]         out_sel_burst,
  output logic [1:0]          out_sel_level
);
  import tlfq_pkg::*;

  localparam int AW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TASK_SLOTS);
  localparam logic [AW-1:0] ROW_LAST = AW'(TASK_SLOTS - 1);

  slot_t      dmem     [TASK_SLOTS];
  logic [AW-1:0] rank_mem [TASK_SLOTS];
  logic [AW-1:0] nrk_mem  [TASK_SLOTS];
  logic [1:0]    grp_mem  [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] valid_r;
  logic [CW-1:0] occ_r, cnt_r;
  logic [AW-1:0] row_r, stg_k_r, acc_r;
  logic          stg_v_r;

  slot_t         dq_r;
  logic [AW-1:0] rq_r, nq_r;
  logic [1:0]    gq_r;

  logic [7:0]  tid_r, tpr_r;
  logic [15:0] tbu_r;
  logic [1:0]  stat_r;
  logic [9:0]  tick_r;
  logic [11:0] thr_r;

  logic          have_r;
  logic [7:0]    b_id_r, b_pr_r;
  logic [15:0]   b_bu_r;
  logic [1:0]    b_lv_r;
  logic [AW-1:0] b_rk_r, b_ix_r;

  logic [1:0]    k_grp_r;
  logic [7:0]    k_id_r;
  logic [AW-1:0] k_rk_r;

  logic          out_valid_r, out_sel_valid_r;
  logic [1:0]    out_status_r, out_sel_level_r;
  logic [7:0]    out_sel_id_r, out_sel_priority_r;
  logic [15:0]   out_sel_burst_r;

  logic [AW-1:0] cidx, raddr;
  logic          cnt_end, scanning, stg_hit, ins_hit, full;
  logic [1:0]    e_lv, n_grp;
  logic          take, ahead, exceed;
  logic [16:0]   w_sum;
  logic [15:0]   w_sat, w_new;
  logic [7:0]    p_new;

  assign cidx     = cnt_r[AW-1:0];
  assign cnt_end  = (cnt_r == CNT_END);
  assign raddr    = (cmd.phase == PH_LOAD) ? row_r : cidx;
  assign scanning = (cmd.phase == PH_SEL) || (cmd.phase == PH_FIX) ||
                    (cmd.phase == PH_AGE) || (cmd.phase == PH_CNT) ||
                    (cmd.phase == PH_COPY);
  assign stg_hit  = stg_v_r && valid_r[stg_k_r];
  assign full     = (occ_r == CNT_END);
  assign ins_hit  = !cnt_end && !valid_r[cidx];

  assign sts.scan_done = cnt_end;
  assign sts.row_last  = (row_r == ROW_LAST);
  assign sts.ins_hit   = ins_hit;
  assign sts.full      = full;
  assign sts.found     = have_r;

  // selection compare
  always_comb begin
    e_lv = level_of(dq_r.prio);
    take = 1'b0;
    if (!have_r || (e_lv < b_lv_r)) begin
      take = 1'b1;
    end else if (e_lv == b_lv_r) begin
      if ((e_lv == LV_1) && (dq_r.burst != b_bu_r)) begin
        take = dq_r.burst < b_bu_r;
      end else if ((e_lv == LV_2) && (dq_r.id != b_id_r)) begin
        take = dq_r.id < b_id_r;
      end else begin
        take = rq_r < b_rk_r;
      end
    end
  end

  // aging update
  always_comb begin
    w_sum  = {1'b0, dq_r.wait_t} + 17'(tick_r);
    w_sat  = w_sum[16] ? 16'hFFFF : w_sum[15:0];
    exceed = w_sat > 16'(thr_r);
    w_new  = exceed ? (w_sat - 16'(thr_r)) : w_sat;
    p_new  = dq_r.prio;
    if (exceed) begin
      if (e_lv == LV_1) begin
        p_new = (dq_r.prio < PRIO_CAP) ? (dq_r.prio + PRIO_STEP) : PRIO_MAX;
      end else begin
        p_new = dq_r.prio + PRIO_STEP;
      end
    end
    n_grp = (exceed && (level_of(p_new) != e_lv)) ? (e_lv - 2'd1) : GRP_STAY;
  end

  // rank recount: does slot j come ahead of the key row
  always_comb begin
    ahead = 1'b0;
    if (stg_hit && (stg_k_r != row_r)) begin
      if (gq_r != k_grp_r) begin
        ahead = gq_r < k_grp_r;
      end else if ((gq_r == 2'd1) && (dq_r.id != k_id_r)) begin
        ahead = dq_r.id < k_id_r;
      end else begin
        ahead = rq_r < k_rk_r;
      end
    end
  end

  // table memories
  always_ff @(posedge clk) begin
    dq_r <= dmem[raddr];
    rq_r <= rank_mem[raddr];
    gq_r <= grp_mem[raddr];
    nq_r <= nrk_mem[raddr];
    if ((cmd.phase == PH_INS) && ins_hit && !full) begin
      dmem[cidx]     <= '{id: tid_r, prio: tpr_r, burst: tbu_r, wait_t: 16'd0};
      rank_mem[cidx] <= occ_r[AW-1:0];
    end
    if ((cmd.phase == PH_AGE) && stg_hit) begin
      dmem[stg_k_r]    <= '{id: dq_r.id, prio: p_new, burst: dq_r.burst, wait_t: w_new};
      grp_mem[stg_k_r] <= n_grp;
    end
    if ((cmd.phase == PH_FIX) && stg_hit && (rq_r > b_rk_r)) begin
      rank_mem[stg_k_r] <= rq_r - AW'(1);
    end
    if ((cmd.phase == PH_COPY) && stg_v_r) begin
      rank_mem[stg_k_r] <= nq_r;
    end
    if (cmd.phase == PH_NWR) begin
      nrk_mem[row_r] <= acc_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stg_k_r <= cidx;
    if (cmd.start_op) begin
      tid_r <= in_task_id;
      tpr_r <= in_task_priority;
      tbu_r <= in_task_burst;
      row_r <= '0;
    end
    if ((cmd.phase == PH_SEL) && stg_hit && take) begin
      b_id_r <= dq_r.id;
      b_pr_r <= dq_r.prio;
      b_bu_r <= dq_r.burst;
      b_lv_r <= e_lv;
      b_rk_r <= rq_r;
      b_ix_r <= stg_k_r;
    end
    if (cmd.phase == PH_KEY) begin
      k_grp_r <= gq_r;
      k_id_r  <= dq_r.id;
      k_rk_r  <= rq_r;
      acc_r   <= '0;
    end
    if ((cmd.phase == PH_CNT) && ahead) begin
      acc_r <= acc_r + AW'(1);
    end
    if (cmd.phase == PH_NWR) begin
      row_r <= row_r + AW'(1);
    end
    if (cmd.finish) begin
      out_status_r       <= stat_r;
      out_sel_valid_r    <= have_r;
      out_sel_id_r       <= have_r ? b_id_r : 8'd0;
      out_sel_priority_r <= have_r ? b_pr_r : 8'd0;
      out_sel_burst_r    <= have_r ? b_bu_r : 16'd0;
      out_sel_level_r    <= have_r ? b_lv_r : LV_NONE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      occ_r       <= '0;
      cnt_r       <= '0;
      stg_v_r     <= 1'b0;
      stat_r      <= ST_OK;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= TICK_RST;
      thr_r       <= THR_RST;
    end else begin
      out_valid_r <= cmd.finish;
      stg_v_r     <= scanning && !cnt_end;
      if (cfg_we) begin
        if (cfg_sel) begin
          thr_r <= cfg_wdata[11:0];
        end else begin
          tick_r <= cfg_wdata[9:0];
        end
      end
      if (cmd.start_op) begin
        stat_r <= ST_OK;
        have_r <= 1'b0;
      end
      if (cmd.scan_clr) begin
        cnt_r <= '0;
      end else if ((scanning || ((cmd.phase == PH_INS) && !ins_hit)) && !cnt_end) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.phase == PH_INS) begin
        if (full) begin
          stat_r <= ST_FULL;
        end else if (ins_hit) begin
          valid_r[cidx] <= 1'b1;
          occ_r         <= occ_r + CW'(1);
        end
      end
      if ((cmd.phase == PH_SEL) && stg_hit && take) begin
        have_r <= 1'b1;
      end
      if (cmd.phase == PH_CLR) begin
        if (have_r) begin
          valid_r[b_ix_r] <= 1'b0;
          occ_r           <= occ_r - CW'(1);
        end else begin
          stat_r <= ST_EMPTY;
        end
      end
    end
  end

  assign cfg_rdata        = cfg_sel ? {20'd0, thr_r} : {22'd0, tick_r};
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sel_valid    = out_sel_valid_r;
  assign out_sel_id       = out_sel_id_r;
  assign out_sel_priority = out_sel_priority_r;
  assign out_sel_burst    = out_sel_burst_r;
  assign out_sel_level    = out_sel_level_r;

endmodule

`default_nettype wire

// ===== hw/rtl/three_level_feedback_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// three_level_feedback_queue_scheduler
// Task table with three priority levels, select-and-remove and aging ticks.
// ----------------------------------------------------------------------------
// One transaction at a time; busy is high from acceptance until the result
// strobe, which lasts one cycle and cannot be stalled. The single read port
// of the slot memories sets the pace of every operation: every pass visits
// one slot a cycle, and the rank recount after aging visits every slot once
// per slot.
// Configuration: tick_interval at byte address 0, aging_threshold at 4.
`default_nettype none

module three_level_feedback_queue_scheduler #(
  parameter int TASK_SLOTS = tlfq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_task_id,
  input  wire logic [7:0]  in_task_priority,
  input  wire logic [15:0] in_task_burst,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_sel_valid,
  output logic [7:0]       out_sel_id,
  output logic [7:0]       out_sel_priority,
  output logic [15:0]      out_sel_burst,
  output logic [1:0]       out_sel_level,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tlfq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  tlfq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  tlfq_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_sel          (paddr[2]),
    .cfg_wdata        (pwdata),
    .cfg_rdata        (prdata),
    .in_task_id       (in_task_id),
    .in_task_priority (in_task_priority),
    .in_task_burst    (in_task_burst),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_sel_valid    (out_sel_valid),
    .out_sel_id       (out_sel_id),
    .out_sel_priority (out_sel_priority),
    .out_sel_burst    (out_sel_burst),
    .out_sel_level    (out_sel_level)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tlfq_chk.sv =====
// ----------------------------------------------------------------------------
// tlfq_chk
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfq_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [1:0] out_status,
  input wire logic       out_sel_valid,
  input wire logic [7:0] out_sel_id,
  input wire logic [1:0] out_sel_level,
  input wire logic       pready
);
  import tlfq_pkg::*;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_sel_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sel_valid) |-> (out_status == ST_OK && out_sel_level != LV_NONE))
    else $error("selected task with bad status or level");

  a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sel_valid) |-> (out_sel_id == 8'd0 && out_sel_level == LV_NONE))
    else $error("fields not cleared without selection");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready) else $error("pready low");

endmodule

bind three_level_feedback_queue_scheduler tlfq_chk u_chk (.*);

`default_nettype wire
